>>> rtl/core/swrs_pkg.sv
// package: types, command codes and status codes of the record stack
`default_nettype none

package swrs_pkg;

    localparam logic [2:0] OPC_PUSH  = 3'd0;
    localparam logic [2:0] OPC_POP   = 3'd1;
    localparam logic [2:0] OPC_CLEAR = 3'd2;
    localparam logic [2:0] OPC_PEEK  = 3'd3;
    localparam logic [2:0] OPC_SCAN  = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef enum logic [2:0] {
        CMD_PUSH,
        CMD_POP,
        CMD_CLEAR,
        CMD_PEEK,
        CMD_SCAN,
        CMD_NOP
    } cmd_e;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_SCAN,
        BK_CLOSE
    } back_state_e;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [63:0]        entry_name;
        logic [7:0]         entry_kind;
        logic signed [31:0] entry_value;
        logic signed [31:0] range_low;
        logic signed [31:0] range_high;
    } in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               has_entry;
        logic [63:0]        out_name;
        logic [7:0]         out_kind;
        logic signed [31:0] out_value;
        logic               is_last;
    } out_t;

    typedef struct packed {
        logic [63:0]        name;
        logic [7:0]         kind;
        logic signed [31:0] value;
    } record_t;

    typedef struct packed {
        cmd_e               kind;
        record_t            rec;
        logic signed [31:0] range_low;
        logic signed [31:0] range_high;
    } cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/swrs_front.sv
// front end: request intake and opcode classification
`default_nettype none

module swrs_front (
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire swrs_pkg::in_t s_data,
    output logic               q_valid,
    input  wire logic          q_ready,
    output swrs_pkg::cmd_t     q_data
);

    always_comb begin
        q_data.rec.name   = s_data.entry_name;
        q_data.rec.kind   = s_data.entry_kind;
        q_data.rec.value  = s_data.entry_value;
        q_data.range_low  = s_data.range_low;
        q_data.range_high = s_data.range_high;
        case (s_data.opcode)
            swrs_pkg::OPC_PUSH: begin
                q_data.kind = swrs_pkg::CMD_PUSH;
            end
            swrs_pkg::OPC_POP: begin
                q_data.kind = swrs_pkg::CMD_POP;
            end
            swrs_pkg::OPC_CLEAR: begin
                q_data.kind = swrs_pkg::CMD_CLEAR;
            end
            swrs_pkg::OPC_PEEK: begin
                q_data.kind = swrs_pkg::CMD_PEEK;
            end
            swrs_pkg::OPC_SCAN: begin
                q_data.kind = swrs_pkg::CMD_SCAN;
            end
            default: begin
                q_data.kind = swrs_pkg::CMD_NOP;
            end
        endcase
    end

    assign q_valid = s_valid;
    assign s_ready = q_ready;

endmodule

`default_nettype wire

>>> rtl/core/swrs_queue.sv
// command queue between front end and execution back end
`default_nettype none

module swrs_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire swrs_pkg::cmd_t in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output swrs_pkg::cmd_t      out_data
);

    swrs_pkg::cmd_t                entry_reg [swrs_pkg::QUEUE_DEPTH];
    logic [swrs_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [swrs_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [swrs_pkg::QCNT_W-1:0]   count_reg, count_next;
    logic                          do_push, do_pop;

    assign in_ready  = (count_reg != swrs_pkg::QCNT_W'(swrs_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign do_push   = in_valid && in_ready;
    assign do_pop    = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/swrs_back.sv
// back end: record store, fill count, scan sequencer and result register
`default_nettype none

module swrs_back #(
    parameter int STACK_DEPTH = 8
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           q_valid,
    output logic                q_ready,
    input  wire swrs_pkg::cmd_t q_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output swrs_pkg::out_t      m_data
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    swrs_pkg::record_t      store_mem [STACK_DEPTH];
    swrs_pkg::record_t      rd_data_reg;

    swrs_pkg::back_state_e  state_reg, state_next;
    logic [CW-1:0]          fill_reg, fill_next;
    logic [AW-1:0]          idx_reg, idx_next;
    logic signed [31:0]     scan_lo_reg, scan_lo_next;
    logic signed [31:0]     scan_hi_reg, scan_hi_next;
    logic                   m_valid_reg, m_valid_next;
    swrs_pkg::out_t         out_reg, out_next;

    logic                   out_free;
    logic                   load_out;
    logic                   wr_en, rd_en;
    logic [AW-1:0]          wr_addr, rd_addr;
    logic [CW-1:0]          fill_dec;
    logic                   is_full, is_empty, hit;
    swrs_pkg::out_t         res;

    assign out_free = !m_valid_reg || m_ready;
    assign fill_dec = fill_reg - CW'(1);
    assign is_full  = (fill_reg == CW'(STACK_DEPTH));
    assign is_empty = (fill_reg == '0);
    assign hit      = (rd_data_reg.value > scan_lo_reg) && (rd_data_reg.value < scan_hi_reg);
    assign wr_addr  = fill_reg[AW-1:0];

    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        idx_next     = idx_reg;
        scan_lo_next = scan_lo_reg;
        scan_hi_next = scan_hi_reg;
        q_ready      = 1'b0;
        load_out     = 1'b0;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = fill_dec[AW-1:0];
        res          = '0;
        res.status   = swrs_pkg::ST_OK;
        res.is_last  = 1'b1;
        case (state_reg)
            swrs_pkg::BK_IDLE: begin
                if (q_valid && out_free) begin
                    q_ready = 1'b1;
                    case (q_data.kind)
                        swrs_pkg::CMD_PUSH: begin
                            load_out = 1'b1;
                            if (is_full) begin
                                res.status = swrs_pkg::ST_FULL;
                            end else begin
                                wr_en     = 1'b1;
                                fill_next = fill_reg + CW'(1);
                            end
                        end
                        swrs_pkg::CMD_POP: begin
                            if (is_empty) begin
                                load_out   = 1'b1;
                                res.status = swrs_pkg::ST_EMPTY;
                            end else begin
                                fill_next  = fill_dec;
                                rd_en      = 1'b1;
                                state_next = swrs_pkg::BK_READ;
                            end
                        end
                        swrs_pkg::CMD_PEEK: begin
                            if (is_empty) begin
                                load_out   = 1'b1;
                                res.status = swrs_pkg::ST_EMPTY;
                            end else begin
                                rd_en      = 1'b1;
                                state_next = swrs_pkg::BK_READ;
                            end
                        end
                        swrs_pkg::CMD_CLEAR: begin
                            load_out  = 1'b1;
                            fill_next = '0;
                        end
                        swrs_pkg::CMD_SCAN: begin
                            if (is_empty) begin
                                load_out = 1'b1;
                            end else begin
                                rd_en        = 1'b1;
                                idx_next     = fill_dec[AW-1:0];
                                scan_lo_next = q_data.range_low;
                                scan_hi_next = q_data.range_high;
                                state_next   = swrs_pkg::BK_SCAN;
                            end
                        end
                        default: begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            swrs_pkg::BK_READ: begin
                if (out_free) begin
                    load_out      = 1'b1;
                    res.has_entry = 1'b1;
                    res.out_name  = rd_data_reg.name;
                    res.out_kind  = rd_data_reg.kind;
                    res.out_value = rd_data_reg.value;
                    state_next    = swrs_pkg::BK_IDLE;
                end
            end
            swrs_pkg::BK_SCAN: begin
                if (!hit || out_free) begin
                    if (hit) begin
                        load_out      = 1'b1;
                        res.has_entry = 1'b1;
                        res.out_name  = rd_data_reg.name;
                        res.out_kind  = rd_data_reg.kind;
                        res.out_value = rd_data_reg.value;
                        res.is_last   = 1'b0;
                    end
                    if (idx_reg == '0) begin
                        state_next = swrs_pkg::BK_CLOSE;
                    end else begin
                        idx_next = idx_reg - AW'(1);
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg - AW'(1);
                    end
                end
            end
            swrs_pkg::BK_CLOSE: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = swrs_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = swrs_pkg::BK_IDLE;
            end
        endcase
        out_next     = load_out ? res : out_reg;
        m_valid_next = load_out ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= swrs_pkg::BK_IDLE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        scan_lo_reg <= scan_lo_next;
        scan_hi_reg <= scan_hi_next;
        out_reg     <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= q_data.rec;
        end
        if (rd_en) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CW'(STACK_DEPTH))
        else $error("fill count above depth");

    a_write_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> !is_full)
        else $error("write into full stack");

    a_scan_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == swrs_pkg::BK_SCAN) |-> !is_empty)
        else $error("scan running on empty stack");

    a_no_entry_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && !res.has_entry) |->
            (res.out_name == '0 && res.out_kind == '0 && res.out_value == '0))
        else $error("record fields set without record");

    a_read_issued: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == swrs_pkg::BK_IDLE && state_next == swrs_pkg::BK_READ) |-> rd_en)
        else $error("read result without memory read");

endmodule

`default_nettype wire

>>> rtl/core/stack_with_range_scan_core.sv
// top level of the record stack with range scan
// result path: push, clear, unused opcodes and refused requests pass the queue entry and
// the result register; pop and peek also pass the registered store read
// throughput: push and clear one request per cycle while results are taken; pop and peek
// hold the back end in a read state; a scan reads one record a cycle unless a hit stalls
// reset: synchronous active-low aresetn empties the stack and the request queue
`default_nettype none

module stack_with_range_scan_core #(
    parameter int STACK_DEPTH = 8
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire swrs_pkg::in_t  s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output swrs_pkg::out_t      m_data
);

    logic           fq_valid, fq_ready;
    swrs_pkg::cmd_t fq_data;
    logic           qb_valid, qb_ready;
    swrs_pkg::cmd_t qb_data;

    swrs_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_data  (fq_data)
    );

    swrs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    swrs_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_data  (qb_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

>>> bench/tb.sv
// testbench for the record stack with range scan: directed table, random requests, shadow stack
`timescale 1ns / 100ps

module tb;

    localparam int STACK_DEPTH = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_REQUESTS = 84;
    localparam int SETTLE_CYCLES = 12;

    localparam logic [2:0] OPC_SPARE5 = 3'd5;
    localparam logic [2:0] OPC_SPARE6 = 3'd6;
    localparam logic [2:0] OPC_SPARE7 = 3'd7;

    localparam logic [31:0] MIN32 = 32'h8000_0000;
    localparam logic [31:0] MAX32 = 32'h7fff_ffff;

    typedef struct {
        swrs_pkg::in_t  req;
        bit             typed;
        swrs_pkg::out_t want;
    } table_row_t;

    logic           aclk    = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    swrs_pkg::in_t  s_data  = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    swrs_pkg::out_t m_data;

    logic quiet   = 1'b0;

    swrs_pkg::record_t shadow_stack [STACK_DEPTH];
    int                shadow_fill = 0;
    swrs_pkg::out_t    pending_results [$];
    table_row_t        directed_rows [$];

    int cycle_count  = 0;
    int n_errors     = 0;
    int n_sent       = 0;
    int n_checked    = 0;
    int n_scan_hits  = 0;

    stack_with_range_scan_core #(
        .STACK_DEPTH(STACK_DEPTH)
    ) uut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still outstanding", $time,
                     pending_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic swrs_pkg::in_t mk_req(logic [2:0] op, logic [63:0] name,
                                             logic [7:0] kind, logic [31:0] value,
                                             logic [31:0] lo, logic [31:0] hi);
        swrs_pkg::in_t req;
        req.opcode      = op;
        req.entry_name  = name;
        req.entry_kind  = kind;
        req.entry_value = value;
        req.range_low   = lo;
        req.range_high  = hi;
        return req;
    endfunction

    function automatic swrs_pkg::out_t plain_reply(logic [1:0] status);
        swrs_pkg::out_t r;
        r         = '0;
        r.status  = status;
        r.is_last = 1'b1;
        return r;
    endfunction

    function automatic void add_row(swrs_pkg::in_t req, bit typed, swrs_pkg::out_t want);
        table_row_t row;
        row.req   = req;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endfunction

    // shadow stack: results of one request, updates the shadow state
    function automatic void model_stack_request(input swrs_pkg::in_t req,
                                                ref swrs_pkg::out_t res[$]);
        swrs_pkg::out_t r;
        r = plain_reply(swrs_pkg::ST_OK);
        case (req.opcode)
            swrs_pkg::OPC_PUSH: begin
                if (shadow_fill >= STACK_DEPTH) begin
                    r.status = swrs_pkg::ST_FULL;
                end else begin
                    shadow_stack[shadow_fill] = '{name: req.entry_name, kind: req.entry_kind,
                                                  value: req.entry_value};
                    shadow_fill++;
                end
                res.push_back(r);
            end
            swrs_pkg::OPC_POP, swrs_pkg::OPC_PEEK: begin
                if (shadow_fill == 0) begin
                    r.status = swrs_pkg::ST_EMPTY;
                end else begin
                    r.has_entry = 1'b1;
                    r.out_name  = shadow_stack[shadow_fill - 1].name;
                    r.out_kind  = shadow_stack[shadow_fill - 1].kind;
                    r.out_value = shadow_stack[shadow_fill - 1].value;
                    if (req.opcode == swrs_pkg::OPC_POP) shadow_fill--;
                end
                res.push_back(r);
            end
            swrs_pkg::OPC_CLEAR: begin
                shadow_fill = 0;
                res.push_back(r);
            end
            swrs_pkg::OPC_SCAN: begin
                for (int i = shadow_fill - 1; i >= 0; i--) begin
                    if ($signed(shadow_stack[i].value) > $signed(req.range_low) &&
                        $signed(shadow_stack[i].value) < $signed(req.range_high)) begin
                        r           = '0;
                        r.status    = swrs_pkg::ST_OK;
                        r.has_entry = 1'b1;
                        r.out_name  = shadow_stack[i].name;
                        r.out_kind  = shadow_stack[i].kind;
                        r.out_value = shadow_stack[i].value;
                        r.is_last   = 1'b0;
                        res.push_back(r);
                    end
                end
                res.push_back(plain_reply(swrs_pkg::ST_OK));
            end
            default: begin
                res.push_back(r);
            end
        endcase
    endfunction

    function automatic swrs_pkg::in_t random_request();
        swrs_pkg::in_t req;
        int            pick;
        req.entry_name = {$urandom, $urandom};
        req.entry_kind = 8'($urandom);
        if ($urandom_range(0, 1)) req.entry_value = $urandom;
        else req.entry_value = $urandom_range(0, 40) - 20;
        if ($urandom_range(0, 9) < 7) begin
            req.range_low  = $urandom_range(0, 30) - 25;
            req.range_high = req.range_low + $urandom_range(0, 30);
        end else begin
            req.range_low  = $urandom;
            req.range_high = $urandom;
        end
        pick = $urandom_range(0, 99);
        if (pick < 40) req.opcode = swrs_pkg::OPC_PUSH;
        else if (pick < 60) req.opcode = swrs_pkg::OPC_POP;
        else if (pick < 68) req.opcode = swrs_pkg::OPC_PEEK;
        else if (pick < 90) req.opcode = swrs_pkg::OPC_SCAN;
        else if (pick < 95) req.opcode = swrs_pkg::OPC_CLEAR;
        else req.opcode = 3'($urandom_range(OPC_SPARE5, OPC_SPARE7));
        return req;
    endfunction

    task automatic send_request(input swrs_pkg::in_t req, input bit typed,
                                input swrs_pkg::out_t want);
        swrs_pkg::out_t res [$];
        if (!quiet && $urandom_range(0, 99) < 6) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_sent++;
        model_stack_request(req, res);
        if (typed) pending_results.push_back(want);
        else foreach (res[k]) pending_results.push_back(res[k]);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    function automatic void field_check(string fname, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, fname, want, got);
            n_errors++;
        end
    endfunction

    always @(posedge aclk) begin
        m_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 6);
    end

    always @(posedge aclk) begin : result_check
        swrs_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, m_data);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (m_data.has_entry && !m_data.is_last) n_scan_hits++;
                field_check("status", 64'(want.status), 64'(m_data.status));
                field_check("has_entry", 64'(want.has_entry), 64'(m_data.has_entry));
                field_check("out_name", want.out_name, m_data.out_name);
                field_check("out_kind", 64'(want.out_kind), 64'(m_data.out_kind));
                field_check("out_value", 64'(want.out_value), 64'(m_data.out_value));
                field_check("is_last", 64'(want.is_last), 64'(m_data.is_last));
            end
        end
    end

    initial begin
        swrs_pkg::out_t none;
        none = '0;

        // empty stack after reset
        add_row(mk_req(swrs_pkg::OPC_POP, '0, '0, '0, '0, '0), 1'b1,
                plain_reply(swrs_pkg::ST_EMPTY));
        add_row(mk_req(swrs_pkg::OPC_PEEK, '1, '1, '1, '1, '1), 1'b1,
                plain_reply(swrs_pkg::ST_EMPTY));
        add_row(mk_req(swrs_pkg::OPC_SCAN, '0, '0, '0, MIN32, MAX32), 1'b1,
                plain_reply(swrs_pkg::ST_OK));
        // fill to the top with extreme records
        add_row(mk_req(swrs_pkg::OPC_PUSH, '1, 8'hff, MAX32, '0, '0), 1'b1,
                plain_reply(swrs_pkg::ST_OK));
        add_row(mk_req(swrs_pkg::OPC_PUSH, '0, 8'h00, MIN32, '1, '1), 1'b1,
                plain_reply(swrs_pkg::ST_OK));
        add_row(mk_req(swrs_pkg::OPC_PUSH, 64'h4142_4344_4546_4748, 8'h41, 32'd0, '0, '0),
                1'b1, plain_reply(swrs_pkg::ST_OK));
        add_row(mk_req(swrs_pkg::OPC_PUSH, 64'h5555_5555_5555_5555, 8'h80, '1, '0, '0), 1'b1,
                plain_reply(swrs_pkg::ST_OK));
        add_row(mk_req(swrs_pkg::OPC_PUSH, 64'haaaa_aaaa_aaaa_aaaa, 8'h7f, 32'd1, '0, '0),
                1'b1, plain_reply(swrs_pkg::ST_OK));
        add_row(mk_req(swrs_pkg::OPC_PUSH, 64'h8000_0000_0000_0001, 8'h55, 32'h8000_0001,
                       '0, '0), 1'b1, plain_reply(swrs_pkg::ST_OK));
        add_row(mk_req(swrs_pkg::OPC_PUSH, 64'h0123_4567_89ab_cdef, 8'haa, 32'h7fff_fffe,
                       '0, '0), 1'b1, plain_reply(swrs_pkg::ST_OK));
        add_row(mk_req(swrs_pkg::OPC_PUSH, 64'hfedc_ba98_7654_3210, 8'h01, 32'd100, '0, '0),
                1'b1, plain_reply(swrs_pkg::ST_OK));
        // full stack refuses the push
        add_row(mk_req(swrs_pkg::OPC_PUSH, '1, '1, '1, '1, '1), 1'b1,
                plain_reply(swrs_pkg::ST_FULL));
        add_row(mk_req(swrs_pkg::OPC_PEEK, '0, '0, '0, '0, '0), 1'b0, none);
        add_row(mk_req(swrs_pkg::OPC_SCAN, '0, '0, '0, MIN32, MAX32), 1'b0, none);
        add_row(mk_req(swrs_pkg::OPC_SCAN, '0, '0, '0, 32'hffff_fffe, 32'd2), 1'b0, none);
        // equal and inverted bounds match nothing
        add_row(mk_req(swrs_pkg::OPC_SCAN, '0, '0, '0, 32'd5, 32'd5), 1'b1,
                plain_reply(swrs_pkg::ST_OK));
        add_row(mk_req(swrs_pkg::OPC_SCAN, '0, '0, '0, MAX32, MIN32), 1'b1,
                plain_reply(swrs_pkg::ST_OK));
        // unused opcodes leave the stack alone
        add_row(mk_req(OPC_SPARE5, '1, '1, '1, '1, '1), 1'b1, plain_reply(swrs_pkg::ST_OK));
        add_row(mk_req(OPC_SPARE6, '1, '1, '1, MIN32, MAX32), 1'b1,
                plain_reply(swrs_pkg::ST_OK));
        add_row(mk_req(OPC_SPARE7, '1, '1, '1, '1, '1), 1'b1, plain_reply(swrs_pkg::ST_OK));
        add_row(mk_req(swrs_pkg::OPC_POP, '1, '1, '1, '1, '1), 1'b0, none);
        add_row(mk_req(swrs_pkg::OPC_POP, '0, '0, '0, '0, '0), 1'b0, none);
        add_row(mk_req(swrs_pkg::OPC_CLEAR, '1, '1, '1, '1, '1), 1'b1,
                plain_reply(swrs_pkg::ST_OK));
        add_row(mk_req(swrs_pkg::OPC_POP, '0, '0, '0, '0, '0), 1'b1,
                plain_reply(swrs_pkg::ST_EMPTY));
        add_row(mk_req(swrs_pkg::OPC_SCAN, '0, '0, '0, MIN32, MAX32), 1'b1,
                plain_reply(swrs_pkg::ST_OK));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
        end
        wait_drained();

        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            quiet <= (i >= 30 && i < 70);
            if (i == 60) wait_drained();
            send_request(random_request(), 1'b0, none);
        end
        quiet <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (pending_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived, expected 0, got %0d", $time,
                     pending_results.size(), pending_results.size());
            n_errors++;
        end

        $display("Sent %0d requests over all opcodes, extremes and full/empty stack;",
                 n_sent);
        $display("checked %0d results, %0d of them range scan records", n_checked,
                 n_scan_hits);
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
